FILE: sv/aesb_pkg.sv
// aesb_pkg: shared types, constants and byte functions of the aes block cipher
// no dependencies
package aesb_pkg;

    localparam int ROUND_KEY_WORDS_DEF = 60;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3 = 3'd4;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;
    localparam logic [1:0] KEY_256 = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_LOAD,
        ST_KEY_EXPAND,
        ST_RK_ADDR,
        ST_RK_WAIT,
        ST_ROUND,
        ST_LAST,
        ST_OUT
    } aesb_state_t;

    // controller to datapath
    typedef struct packed {
        logic       load_block;   // capture input block
        logic       key_load;     // write key word from key registers
        logic       key_expand;   // write one expanded key word
        logic [5:0] key_idx;      // word index being written
        logic [5:0] rk_idx;       // round key read base (word)
        logic [1:0] rk_col;       // column being fetched
        logic       rk_capture;   // capture read data into column
        logic       do_initial;   // apply initial add round key
        logic       do_round;     // apply a round (full unless last_round)
        logic       last_round;   // round without mix columns
        logic       out_load;     // present result
    } aesb_cmd_t;

    typedef struct packed {
        logic       dec;
        logic [1:0] sel;
    } aesb_status_t;

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] aa;
        p  = 8'h00;
        aa = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ aa;
            aa = xt(aa);
        end
        gmul = p;
    endfunction

    // inverse in gf(2^8) by table would be large; use explicit sbox table
    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    function automatic logic [7:0] inv_sub_byte(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sub_byte = t[x];
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        sbox_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

FILE: sv/aes_block_cipher.sv
// aes_block_cipher: top level of the aes ecb block cipher
// depends on aesb_pkg, aesb_ctrl, aesb_dp and aesb_ram
//
// usage:
//   cfg channel writes key_size (index 0) and key parts (index 1..4); write
//   only while the block is idle. any write invalidates the key schedule.
//   s_axis carries one 128-bit block with a cmd bit in tuser (0 encrypt,
//   1 decrypt); m_axis returns the 128-bit result.
// sequence:
//   each of the nr+1 key additions (10, 12 or 14 rounds) passes an address
//   state, a fetch of the four round-key words one by one from the single read
//   port of the key store, and a round state; the output register is then
//   loaded. the block works on one block at a time. the first block after reset or
//   a configuration write adds a schedule expansion of one word a cycle,
//   44, 52 or 60 words in all.
// reset: clears the controller, the key registers, the output register and
//   the schedule flag; the key store needs no clearing since it is
//   rewritten before use.
// stall: the result waits in the output register while m_axis_tready is
//   low; a new block is taken once the result has left.
module aes_block_cipher
    import aesb_pkg::*;
#(
    parameter int ROUND_KEY_WORDS = ROUND_KEY_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [127:0]         s_axis_tdata,  // block_lo, block_hi
    input  logic                 s_axis_tuser,  // cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [127:0]         m_axis_tdata   // result_lo, result_hi
);

    aesb_cmd_t    cmd;
    aesb_status_t status;
    logic [127:0] result;
    logic         cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    aesb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_wr),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    aesb_dp #(
        .ROUND_KEY_WORDS(ROUND_KEY_WORDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_wr),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_cmd   (s_axis_tuser),
        .in_block ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

    // block byte 0 is msb of block_hi, which sits in the low tdata word
    assign m_axis_tdata = {result[63:0], result[127:64]};

`ifndef SYNTH
    // a result never appears together with a new input acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input accepted while result pending");

    // a stalled result keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

    // expansion and rounds never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !((cmd.key_load || cmd.key_expand) && (cmd.do_round || cmd.do_initial)))
        else $error("key expansion overlaps round");
`endif

endmodule

FILE: sv/aesb_ram.sv
// aesb_ram: generic ram with one write port and one registered read port
// no dependencies
module aesb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/aesb_ctrl.sv
// aesb_ctrl: sequencer for key expansion and cipher rounds
// depends on aesb_pkg
module aesb_ctrl
    import aesb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  aesb_status_t status,
    output aesb_cmd_t    cmd
);

    aesb_state_t state_reg, state_next;
    logic        sched_ok_reg, sched_ok_next;
    logic [5:0]  idx_reg, idx_next;
    logic [3:0]  rnd_reg, rnd_next;
    logic [1:0]  col_reg, col_next;
    logic        ov_reg, ov_next;

    logic [3:0] nk;
    logic [3:0] nr;
    logic [5:0] total;

    assign nk    = 4'd4 + {1'b0, status.sel, 1'b0};
    assign nr    = nk + 4'd6;
    assign total = {nr, 2'b00} + 6'd4;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sched_ok_reg <= 1'b0;
            idx_reg      <= '0;
            rnd_reg      <= '0;
            col_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sched_ok_reg <= sched_ok_next;
            idx_reg      <= idx_next;
            rnd_reg      <= rnd_next;
            col_reg      <= col_next;
            ov_reg       <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == ST_IDLE) && !ov_reg;

    // next state and commands
    always_comb
    begin
        logic [3:0] key_rnd;
        state_next    = state_reg;
        sched_ok_next = sched_ok_reg && !cfg_valid;
        idx_next      = idx_reg;
        rnd_next      = rnd_reg;
        col_next      = col_reg;
        ov_next       = ov_reg && !out_ready;
        cmd           = '0;
        key_rnd       = status.dec ? (nr - rnd_reg) : rnd_reg;
        cmd.key_idx   = idx_reg;
        cmd.rk_idx    = {key_rnd, 2'b00};
        cmd.rk_col    = col_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load_block = 1'b1;
                    rnd_next       = '0;
                    col_next       = '0;
                    idx_next       = '0;
                    state_next     = sched_ok_reg ? ST_RK_ADDR : ST_KEY_LOAD;
                end
            end
            ST_KEY_LOAD:
            begin
                cmd.key_load = 1'b1;
                idx_next     = idx_reg + 6'd1;
                if (idx_reg + 6'd1 == {2'b00, nk})
                    state_next = ST_KEY_EXPAND;
            end
            ST_KEY_EXPAND:
            begin
                cmd.key_expand = 1'b1;
                idx_next       = idx_reg + 6'd1;
                if (idx_reg + 6'd1 == total)
                begin
                    sched_ok_next = 1'b1;
                    state_next    = ST_RK_ADDR;
                end
            end
            ST_RK_ADDR:
            begin
                // address the first column; data arrives next cycle
                col_next   = 2'd1;
                cmd.rk_col = 2'd0;
                state_next = ST_RK_WAIT;
            end
            ST_RK_WAIT:
            begin
                cmd.rk_capture = 1'b1;
                cmd.rk_col     = col_reg;
                col_next       = col_reg + 2'd1;
                if (col_reg == 2'd0)
                    state_next = (rnd_reg == 4'd0) ? ST_ROUND :
                                 (rnd_reg == nr) ? ST_LAST : ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg == 4'd0)
                    cmd.do_initial = 1'b1;
                else
                    cmd.do_round = 1'b1;
                rnd_next   = rnd_reg + 4'd1;
                col_next   = '0;
                state_next = ST_RK_ADDR;
            end
            ST_LAST:
            begin
                cmd.do_round   = 1'b1;
                cmd.last_round = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/aesb_dp.sv
// aesb_dp: key registers, round-key store and round datapath
// depends on aesb_pkg and aesb_ram
module aesb_dp
    import aesb_pkg::*;
#(
    parameter int ROUND_KEY_WORDS = ROUND_KEY_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_cmd,
    input  logic [127:0]         in_block,
    input  aesb_cmd_t            cmd,
    output aesb_status_t         status,
    output logic [127:0]         result
);

    localparam int AW = $clog2(ROUND_KEY_WORDS);

    logic [1:0]   key_size_reg;
    logic [63:0]  key_part_reg [4];
    logic         dec_reg;
    logic [127:0] state_reg;
    logic [127:0] rk_reg;
    logic [127:0] result_reg;
    logic [31:0]  hist_reg [8];  // last nk words written
    logic [7:0]   rc_reg;
    logic [3:0]   ph_reg;        // index mod nk during expansion
    logic [1:0]   sel;

    // requested key size (code 3 taken as 256), reduced until its schedule fits the store
    always_comb
    begin
        logic [1:0] s;
        s = (key_size_reg >= KEY_256) ? KEY_256 : key_size_reg;
        if (s == KEY_256 && ROUND_KEY_WORDS < 60)
            s = KEY_192;
        if (s == KEY_192 && ROUND_KEY_WORDS < 52)
            s = KEY_128;
        sel = s;
    end

    assign status.dec = dec_reg;
    assign status.sel = sel;
    assign result     = result_reg;

    logic [3:0] nk;
    logic [2:0] top_idx;
    assign nk      = 4'd4 + {1'b0, sel, 1'b0};
    assign top_idx = 3'(nk - 4'd1);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= '0;
            for (int i = 0; i < 4; i++)
                key_part_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KEY_SIZE:   key_size_reg    <= cfg_data[1:0];
                REG_KEY_PART_0: key_part_reg[0] <= cfg_data;
                REG_KEY_PART_1: key_part_reg[1] <= cfg_data;
                REG_KEY_PART_2: key_part_reg[2] <= cfg_data;
                REG_KEY_PART_3: key_part_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // key word generation
    logic [31:0] load_word, exp_word, wr_word, t_prev, t_rot;
    assign load_word = cmd.key_idx[0] ? key_part_reg[cmd.key_idx[2:1]][31:0]
                                      : key_part_reg[cmd.key_idx[2:1]][63:32];
    assign t_prev = hist_reg[top_idx];
    assign t_rot  = {t_prev[23:0], t_prev[31:24]};
    always_comb
    begin
        if (ph_reg == 4'd0)
            exp_word = sbox_word(t_rot) ^ {rc_reg, 24'h0};
        else if (nk > 4'd6 && ph_reg == 4'd4)
            exp_word = sbox_word(t_prev);
        else
            exp_word = t_prev;
        exp_word = exp_word ^ hist_reg[0];
    end
    assign wr_word = cmd.key_load ? load_word : exp_word;

    // history shift line: hist[nk-1] is newest, hist[0] is word i-nk
    always_ff @(posedge clk)
    begin
        if (cmd.key_load || cmd.key_expand)
        begin
            for (int i = 0; i < 7; i++)
                if (i + 1 < int'(nk))
                    hist_reg[i] <= hist_reg[i+1];
            hist_reg[top_idx] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= 8'h01;
            ph_reg <= '0;
        end
        else if (cmd.key_load)
        begin
            rc_reg <= 8'h01;
            ph_reg <= '0;
        end
        else if (cmd.key_expand)
        begin
            ph_reg <= (ph_reg + 4'd1 == nk) ? 4'd0 : ph_reg + 4'd1;
            if (ph_reg == 4'd0)
                rc_reg <= xt(rc_reg);
        end
    end

    // round-key store
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;
    assign raddr = AW'(cmd.rk_idx + {4'd0, cmd.rk_col});

    aesb_ram #(
        .WIDTH(32),
        .DEPTH(ROUND_KEY_WORDS)
    ) u_rk_ram (
        .clk  (clk),
        .we   (cmd.key_load || cmd.key_expand),
        .waddr(AW'(cmd.key_idx)),
        .wdata(wr_word),
        .raddr(raddr),
        .rdata(rdata)
    );

    // round key column assembly (capture column col-1)
    always_ff @(posedge clk)
    begin
        if (cmd.rk_capture)
        begin
            unique case (cmd.rk_col - 2'd1)
                2'd0: rk_reg[127:96] <= rdata;
                2'd1: rk_reg[95:64]  <= rdata;
                2'd2: rk_reg[63:32]  <= rdata;
                2'd3: rk_reg[31:0]   <= rdata;
                default: ;
            endcase
        end
    end

    // round function
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   m [16];
    logic [127:0] sb, mx, after;
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            s[i] = state_reg[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                if (dec_reg)
                    t[r + 4*c] = inv_sub_byte(s[r + 4*((c + 4 - r) % 4)]);
                else
                    t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
            end
        for (int i = 0; i < 16; i++)
            sb[127 - 8*i -: 8] = t[i];
        // decrypt adds the key before inverse mix
        if (dec_reg)
            sb = sb ^ rk_reg;
        for (int i = 0; i < 16; i++)
            t[i] = sb[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                if (dec_reg)
                    m[r + 4*c] = gmul(8'h0e, t[4*c + r]) ^
                                 gmul(8'h0b, t[4*c + (r+1)%4]) ^
                                 gmul(8'h0d, t[4*c + (r+2)%4]) ^
                                 gmul(8'h09, t[4*c + (r+3)%4]);
                else
                    m[r + 4*c] = xt(t[4*c + r]) ^ xt(t[4*c + (r+1)%4]) ^
                                 t[4*c + (r+1)%4] ^ t[4*c + (r+2)%4] ^
                                 t[4*c + (r+3)%4];
            end
        for (int i = 0; i < 16; i++)
            mx[127 - 8*i -: 8] = m[i];
        if (cmd.last_round)
            after = dec_reg ? sb : (sb ^ rk_reg);
        else
            after = dec_reg ? mx : (mx ^ rk_reg);
    end

    // block state
    always_ff @(posedge clk)
    begin
        if (cmd.load_block)
        begin
            state_reg <= in_block;
            dec_reg   <= in_cmd;
        end
        else if (cmd.do_initial)
            state_reg <= state_reg ^ rk_reg;
        else if (cmd.do_round)
            state_reg <= after;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_reg <= '0;
        else if (cmd.out_load)
            result_reg <= state_reg;
    end

endmodule

FILE: sim/tb.sv
// tb: self-checking testbench of aes_block_cipher, ecb encrypt and decrypt
// depends on aesb_pkg and the aes_block_cipher rtl
module tb;
    import aesb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;
    localparam int   DRAIN_CYCLES = 160;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [127:0]         s_axis_tdata;  // block_lo, block_hi
    logic                 s_axis_tuser;  // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [127:0]         m_axis_tdata;  // result_lo, result_hi

    aes_block_cipher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // cipher model state
    logic [7:0]   fwd_tab [256];
    logic [7:0]   inv_tab [256];
    logic [1:0]   key_size_q;
    logic [63:0]  key_q [4];
    logic [31:0]  sched [60];
    logic         sched_valid;
    int           num_rounds;

    // expected results, oldest first
    logic [127:0] pending_results [$];

    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;

    // clock and watchdog
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("aes_block_cipher: mismatch");
        $finish;
    end

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = xtime(a);
        end
        return p;
    endfunction

    // s-boxes from the field inverse and the affine map
    task automatic build_tables();
        logic [7:0] inv;
        logic [7:0] b;
        for (int v = 0; v < 256; v++)
        begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++)
                inv = gf_mul(inv, v[7:0]);
            if (v == 0)
                inv = 8'h00;
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_tab[v] = b;
            inv_tab[b] = v[7:0];
        end
    endtask

    task automatic expand_keys();
        int sel;
        int nk;
        logic [31:0] t;
        logic [7:0]  rc;
        sel = (key_size_q >= KEY_256) ? 2 : int'(key_size_q);
        nk = 4 + 2 * sel;
        num_rounds = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_q[i / 2][31:0] : key_q[i / 2][63:32];
        for (int i = nk; i < 4 * (num_rounds + 1); i++)
        begin
            t = sched[i - 1];
            if (i % nk == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
                t[31:24] ^= rc;
                rc = xtime(rc);
            end
            else if (nk > 6 && i % nk == 4)
                t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
            sched[i] = t ^ sched[i - nk];
        end
        sched_valid = 1'b1;
    endtask

    // byte i of a block sits at bits 127-8i down
    function automatic logic [127:0] xor_round_key(input logic [127:0] v, input int rnd);
        for (int c = 0; c < 4; c++)
            v[127 - 32 * c -: 32] ^= sched[4 * rnd + c];
        return v;
    endfunction

    function automatic logic [127:0] shift_sub(input logic [127:0] v, input logic inv);
        logic [127:0] o;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                o[127 - 8 * (r + 4 * c) -: 8] = inv ? inv_tab[v[127 - 8 * (r + 4 * src) -: 8]]
                                                     : fwd_tab[v[127 - 8 * (r + 4 * src) -: 8]];
            end
        return o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] v, input logic inv);
        logic [7:0] m [4];
        logic [7:0] acc;
        logic [127:0] o;
        if (inv)
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_mul(m[(k + 4 - r) % 4], v[127 - 8 * (k + 4 * c) -: 8]);
                o[127 - 8 * (r + 4 * c) -: 8] = acc;
            end
        return o;
    endfunction

    function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] v);
        if (!dec)
        begin
            v = xor_round_key(v, 0);
            for (int rnd = 1; rnd <= num_rounds; rnd++)
            begin
                v = shift_sub(v, 1'b0);
                if (rnd < num_rounds)
                    v = mix_cols(v, 1'b0);
                v = xor_round_key(v, rnd);
            end
        end
        else
        begin
            v = xor_round_key(v, num_rounds);
            for (int rnd = num_rounds; rnd > 0; rnd--)
            begin
                v = shift_sub(v, 1'b1);
                v = xor_round_key(v, rnd - 1);
                if (rnd > 1)
                    v = mix_cols(v, 1'b1);
            end
        end
        return v;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        error_count++;
        $display("error at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // result checker: samples at the rising edge, moves tready at the falling edge
    initial
    begin
        logic [127:0] want;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                    report("unexpected result_hi", m_axis_tdata[63:0], 64'h0);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[63:0] !== want[127:64])
                        report("result_hi", m_axis_tdata[63:0], want[127:64]);
                    if (m_axis_tdata[127:64] !== want[63:0])
                        report("result_lo", m_axis_tdata[127:64], want[63:0]);
                end
            end
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one block transaction; tvalid stays high into the next call unless it idles
    task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        if (!sched_valid)
            expand_keys();
        pending_results.push_back(cipher_block(cmd, {hi, lo}));
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {lo, hi};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // let the block drain before touching the key registers
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            REG_KEY_SIZE:   key_size_q = value[1:0];
            REG_KEY_PART_0: key_q[0] = value;
            REG_KEY_PART_1: key_q[1] = value;
            REG_KEY_PART_2: key_q[2] = value;
            REG_KEY_PART_3: key_q[3] = value;
            default:        return;
        endcase
        sched_valid = 1'b0;
    endtask

    task automatic load_key(input logic [1:0] ksz, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        wait_idle();
        write_reg(REG_KEY_PART_3, k3);
        write_reg(REG_KEY_PART_1, k1);
        write_reg(REG_KEY_SIZE, {62'h0, ksz});
        write_reg(REG_KEY_PART_0, k0);
        write_reg(REG_KEY_PART_2, k2);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(15))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // standard vectors, extremes, all key sizes and the odd register cases
    task automatic test_directed();
        send_block(CMD_ENC, 64'h0, 64'h0);
        send_block(CMD_DEC, '1, '1);
        load_key(KEY_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
        send_block(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(CMD_ENC, '1, 64'h0);
        load_key(KEY_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h0);
        send_block(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        load_key(KEY_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        // unused size code behaves as a 256-bit key
        load_key(2'd3, '1, '1, '1, '1);
        send_block(CMD_ENC, 64'h0, '1);
        send_block(CMD_DEC, '1, 64'h0);
        // a write to an index past the list leaves the key registers alone
        wait_idle();
        write_reg(REG_UNUSED, '1);
        send_block(CMD_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
        // a single part rewritten between blocks
        wait_idle();
        write_reg(REG_KEY_PART_2, 64'h0);
        send_block(CMD_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int keys,
                               input int per_key);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < keys; k++)
        begin
            load_key(2'($urandom_range(3)), rand_word(), rand_word(), rand_word(),
                     rand_word());
            for (int n = 0; n < per_key; n++)
                send_block(1'($urandom_range(1)), rand_word(), rand_word());
        end
    endtask

    // receiver holds off while blocks keep coming, so the input backs up
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_key(KEY_256, rand_word(), rand_word(), rand_word(), rand_word());
        hold_cycles = 600;
        for (int n = 0; n < 12; n++)
            send_block(1'($urandom_range(1)), rand_word(), rand_word());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_KEY_SIZE;
        cfg_data       = 64'h0;
        s_axis_tvalid  = 1'b0;
        s_axis_tuser   = CMD_ENC;
        s_axis_tdata   = 128'h0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        key_size_q     = KEY_128;
        key_q          = '{default: 64'h0};
        sched_valid    = 1'b0;
        num_rounds     = 10;
        build_tables();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(0, 0, 5, 110);
        test_random(80, 0, 4, 110);
        test_random(0, 80, 4, 110);
        test_random(12, 12, 5, 110);
        test_backpressure();

        wait_idle();
        if (error_count == 0)
            $display("aes_block_cipher: match");
        else
            $display("aes_block_cipher: mismatch");
        $finish;
    end

endmodule
